// File: src/rmfp_pkg.sv
// Shared constants, codes and types for the rotated mono framebuffer plotter.
package rmfp_pkg;

  localparam int PANEL_WIDTH     = 128;
  localparam int PANEL_HEIGHT    = 296;
  localparam int VISIBLE_COLUMNS = 128;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Signed coordinate width, wide enough for 0..511 and mirrored negatives.
  localparam int CW = 11;
  // Width of a plot address before the range check.
  localparam int PLOT_AW = 16;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int ODEPTH   = 4;
  localparam int OPTR_W   = $clog2(ODEPTH);

  localparam logic OP_PLOT = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // One classified command for the back end.
  typedef struct packed {
    logic              is_read;
    logic              zero;
    logic              white;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } cmd_t;

endpackage

// File: src/rotated_mono_framebuffer_plotter.sv
// Top level of the rotated mono framebuffer plotter.
// A read's byte passes the front, queue, stage and result registers to out_read_byte.
// Throughput: one transaction per cycle while full is low and a result slot is free,
// set by the store's read-modify-write of a byte each cycle with one-deep forwarding.
// Reset: rotation returns to 0 and the store is swept to white, one byte a cycle,
// over all STORE_BYTES bytes (4736 by default); full stays high through the sweep.
module rotated_mono_framebuffer_plotter import rmfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [8:0]  in_pixel_x,
  input  logic [8:0]  in_pixel_y,
  input  logic        in_pixel_white,
  input  logic [12:0] in_byte_index,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_read_byte
);

  // Front to queue.
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  // Queue to back end.
  logic q_valid, q_pop;
  cmd_t q_cmd;
  // Back end sweeping the store after reset.
  logic back_busy;

  // Classify each transaction; drop plots that fall outside the panel.
  rmfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .push           (push),
    .back_busy      (back_busy),
    .full           (full),
    .in_operation   (in_operation),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_white (in_pixel_white),
    .in_byte_index  (in_byte_index),
    .cmd_valid      (fr_valid),
    .cmd            (fr_cmd),
    .cmd_ready      (fr_ready)
  );

  // Decouple the front end from stalls on the result side.
  rmfp_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_cmd   (fr_cmd),
    .wr_ready (fr_ready),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .rd_pop   (q_pop)
  );

  // Carry out plots and reads against the store; queue read results.
  rmfp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd           (q_cmd),
    .cmd_pop       (q_pop),
    .busy          (back_busy),
    .empty         (empty),
    .pop           (pop),
    .out_read_byte (out_read_byte)
  );

endmodule

// File: src/rmfp_front.sv
// Front end: holds rotation, checks and maps coordinates, classifies items.
module rmfp_front import rmfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        push,
  input  logic        back_busy,
  output logic        full,
  input  logic        in_operation,
  input  logic [8:0]  in_pixel_x,
  input  logic [8:0]  in_pixel_y,
  input  logic        in_pixel_white,
  input  logic [12:0] in_byte_index,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  logic [1:0] rotation_r;
  logic       fr_v_r;
  cmd_t       fr_cmd_r;

  logic                 accept;
  logic                 keep;
  cmd_t                 cmd_nxt;
  logic signed [CW-1:0] x_s, y_s, lw, lh, px, py;
  logic [PLOT_AW-1:0]   plot_addr;
  logic                 plot_ok;
  logic                 swapped;

  assign x_s     = CW'(in_pixel_x);
  assign y_s     = CW'(in_pixel_y);
  assign swapped = (rotation_r == ROT_90) || (rotation_r == ROT_270);
  assign lw      = swapped ? CW'(PANEL_HEIGHT) : CW'(PANEL_WIDTH);
  assign lh      = swapped ? CW'(PANEL_WIDTH) : CW'(PANEL_HEIGHT);

  always_comb begin
    unique case (rotation_r)
      ROT_90: begin
        px = CW'(VISIBLE_COLUMNS - 1) - y_s;
        py = x_s;
      end
      ROT_180: begin
        px = CW'(VISIBLE_COLUMNS - 1) - x_s;
        py = CW'(PANEL_HEIGHT - 1) - y_s;
      end
      ROT_270: begin
        px = y_s;
        py = CW'(PANEL_HEIGHT - 1) - x_s;
      end
      default: begin
        px = x_s;
        py = y_s;
      end
    endcase
  end

  assign plot_addr = PLOT_AW'(px[CW-2:3]) + PLOT_AW'(py[CW-2:0]) * PLOT_AW'(ROW_BYTES);

  assign plot_ok = (x_s < lw) && (y_s < lh)
                && !px[CW-1] && (px < CW'(PANEL_WIDTH))
                && !py[CW-1] && (py < CW'(PANEL_HEIGHT))
                && (plot_addr < PLOT_AW'(STORE_BYTES));

  always_comb begin
    cmd_nxt.is_read = (in_operation == OP_READ);
    cmd_nxt.white   = in_pixel_white;
    cmd_nxt.mask    = 8'h80 >> px[2:0];
    if (in_operation == OP_READ) begin
      cmd_nxt.zero = !(32'(in_byte_index) < STORE_BYTES);
      cmd_nxt.addr = cmd_nxt.zero ? '0 : ADDR_W'(in_byte_index);
    end else begin
      cmd_nxt.zero = 1'b0;
      cmd_nxt.addr = ADDR_W'(plot_addr);
    end
  end

  // Drop plots that miss the panel; every read goes on.
  assign keep   = (in_operation == OP_READ) || plot_ok;
  assign full   = back_busy || (fr_v_r && !cmd_ready);
  assign accept = push && !full;

  assign cmd_valid = fr_v_r;
  assign cmd       = fr_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= ROT_0;
      fr_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        rotation_r <= cfg_data;
      end
      if (accept) begin
        fr_v_r <= keep;
      end else if (cmd_ready) begin
        fr_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: src/rmfp_cmd_queue.sv
// Short command queue between the front end and the back end.
module rmfp_cmd_queue import rmfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  input  cmd_t wr_cmd,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_pop
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_wr, do_rd;

  assign wr_ready = (cnt_r != (QPTR_W + 1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = q_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (QPTR_W + 1)'(do_wr) - (QPTR_W + 1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wp_r] <= wr_cmd;
    end
  end

endmodule

// File: src/rmfp_back.sv
// Back end: frame store, clearing pass, read-modify-write and result queue.
module rmfp_back import rmfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       busy,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_read_byte
);

  logic [7:0]        store [STORE_BYTES];
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [7:0]        rd_data_r;
  logic              s1_v_r;
  cmd_t              s1_r;
  logic              lw_v_r;
  logic [ADDR_W-1:0] lw_addr_r;
  logic [7:0]        lw_data_r;

  logic [7:0]        oq_r [ODEPTH];
  logic [OPTR_W-1:0] owp_r, orp_r;
  logic [OPTR_W:0]   ocnt_r;

  logic              issue;
  logic              s1_plot, s1_read, o_pop;
  logic [7:0]        cur, new_byte;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  // Reserve a result slot for a read already in flight.
  assign issue   = cmd_valid && !clearing_r
                && ((ocnt_r + (OPTR_W + 1)'(s1_v_r && s1_r.is_read)) < (OPTR_W + 1)'(ODEPTH));
  assign cmd_pop = issue;
  assign busy    = clearing_r;

  assign s1_plot  = s1_v_r && !s1_r.is_read;
  assign s1_read  = s1_v_r && s1_r.is_read;
  assign cur      = (lw_v_r && (lw_addr_r == s1_r.addr)) ? lw_data_r : rd_data_r;
  assign new_byte = s1_r.white ? (cur | s1_r.mask) : (cur & ~s1_r.mask);

  assign we    = clearing_r || s1_plot;
  assign waddr = clearing_r ? clr_addr_r : s1_r.addr;
  assign wdata = clearing_r ? 8'hFF : new_byte;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= store[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      s1_v_r     <= 1'b0;
      lw_v_r     <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(STORE_BYTES - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      s1_v_r <= issue;
      lw_v_r <= s1_plot;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= cmd;
    end
    if (s1_plot) begin
      lw_addr_r <= s1_r.addr;
      lw_data_r <= new_byte;
    end
  end

  assign empty         = (ocnt_r == '0);
  assign o_pop         = pop && !empty;
  assign out_read_byte = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (s1_read) begin
        owp_r <= owp_r + 1'b1;
      end
      if (o_pop) begin
        orp_r <= orp_r + 1'b1;
      end
      ocnt_r <= ocnt_r + (OPTR_W + 1)'(s1_read) - (OPTR_W + 1)'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_read) begin
      oq_r[owp_r] <= s1_r.zero ? 8'h00 : cur;
    end
  end

endmodule
